### hdl/aefcc_pkg.sv
// ----------------------------------------------------------------------------
// aefcc_pkg
// Shared constants and CRC helpers for the encoder frame checker.
// ----------------------------------------------------------------------------
package aefcc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 22;
    localparam int unsigned CRC_DATA_W = 26;
    localparam int unsigned IDX_W     = 3;

    // frame byte index codes
    localparam logic [IDX_W-1:0] IDX_FIRST = 3'd1;
    localparam logic [IDX_W-1:0] IDX_LAST  = 3'd5;
    localparam logic [IDX_W-1:0] IDX_IDLE  = 3'd6;

    localparam logic [31:0] CRC_POLY = 32'hDB00_0000;

    typedef logic [CRC_DATA_W-1:0][7:0] t_crc_cols;

    // Bitwise long division as the encoder does it; used at elaboration only.
    function automatic logic [7:0] crc_rem(input logic [31:0] word);
        logic [31:0] w;
        w = word;
        for (int k = 0; k < 31; k++) begin
            if (w[31]) w = w ^ CRC_POLY;
            w = {w[30:0], 1'b0};
        end
        if (w[31]) w = w ^ CRC_POLY;
        return w[31:24];
    endfunction

    function automatic t_crc_cols crc_cols_init();
        t_crc_cols cols;
        for (int i = 0; i < CRC_DATA_W; i++) begin
            cols[i] = crc_rem(32'd1 << i);
        end
        return cols;
    endfunction

    // remainder of each single data bit; the division is linear in GF(2)
    localparam t_crc_cols CRC_COLS = crc_cols_init();

    function automatic logic [7:0] crc_calc(input logic [CRC_DATA_W-1:0] data);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < CRC_DATA_W; i++) begin
            if (data[i]) r = r ^ CRC_COLS[i];
        end
        return r;
    endfunction

endpackage

### hdl/absolute_encoder_frame_crc_check_top.sv
// ----------------------------------------------------------------------------
// absolute_encoder_frame_crc_check_top
// Collects a six-byte encoder frame, checks its CRC7 and holds the position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one received byte per beat;
//   i_frame_start marks byte 0, whose contents are ignored. Bytes 1..5
//   follow. Bytes without a start mark outside a frame are dropped, and a
//   start mark always restarts the frame.
//   Output channel (o_valid / i_stall) carries one result beat per frame,
//   loaded into the result register at the edge that takes byte 5, so the
//   beat shows in the cycle after byte 5 is taken.
//   Each beat shows the flags, crc_ok and the held position, which is
//   replaced only when the CRC matches and the valid flag is set.
//   Throughput: one byte per cycle unless stalled. The CRC is an XOR tree over
//   the 26 checked bits, so the whole check fits in the cycle that takes
//   byte 5. o_stall rises only when the result register is full and stalled
//   and the next byte would complete a frame; other bytes are taken meanwhile.
//   Reset (i_rst_n low, synchronous) clears the held position to zero,
//   drops any partial frame and empties the result register.
// ----------------------------------------------------------------------------
module absolute_encoder_frame_crc_check_top
    import aefcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_frame_start,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [POS_W-1:0]  o_position,
    output logic              o_crc_ok,
    output logic              o_position_valid,
    output logic              o_synchronized,
    output logic              o_zero_point_default,
    output logic              o_stale_data,
    output logic              o_position_updated
);

    logic [IDX_W-1:0]   r_idx;
    logic [31:0]        r_frame;      // bytes 1..4, byte 1 highest
    logic [POS_W-1:0]   r_held_pos;
    logic               r_out_valid;
    logic [5:0]         r_out_flags;

    logic               accept;
    logic               last_beat;
    logic [BYTE_W-1:0]  b1, b2, b3, b4;
    logic [CRC_DATA_W-1:0] crc_bits;
    logic [7:0]         crc_val;
    logic               n_ok;
    logic               n_upd;
    logic [POS_W-1:0]   n_pos;

    assign o_stall   = r_out_valid && i_stall && (r_idx == IDX_LAST);
    assign accept    = i_valid && !o_stall;
    assign last_beat = accept && !i_frame_start && (r_idx == IDX_LAST);

    assign b1 = r_frame[31:24];
    assign b2 = r_frame[23:16];
    assign b3 = r_frame[15:8];
    assign b4 = r_frame[7:0];

    assign crc_bits = {b1[0], b2, b3, b4, i_rx_byte[7]};
    assign crc_val  = crc_calc(crc_bits);
    assign n_ok     = (crc_val == {1'b0, i_rx_byte[6:0]});
    assign n_upd    = n_ok && b2[7];
    assign n_pos    = {b2[5:0], b3, b4};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= IDX_IDLE;
            r_held_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (i_frame_start) begin
                    r_idx <= IDX_FIRST;
                end else if (r_idx >= IDX_FIRST && r_idx < IDX_LAST) begin
                    r_idx <= r_idx + 3'd1;
                end else if (r_idx == IDX_LAST) begin
                    r_idx <= IDX_IDLE;
                end
            end
            if (last_beat && n_upd) r_held_pos <= n_pos;
            if (last_beat) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_frame_start && r_idx >= IDX_FIRST && r_idx < IDX_LAST) begin
            r_frame <= {r_frame[23:0], i_rx_byte};
        end
        if (last_beat) begin
            r_out_flags <= {n_ok, b2[7], b2[6], b1[0], i_rx_byte[7], n_upd};
        end
    end

    assign o_valid              = r_out_valid;
    assign o_position           = r_held_pos;
    assign o_crc_ok             = r_out_flags[5];
    assign o_position_valid     = r_out_flags[4];
    assign o_synchronized       = r_out_flags[3];
    assign o_zero_point_default = r_out_flags[2];
    assign o_stale_data         = r_out_flags[1];
    assign o_position_updated   = r_out_flags[0];

endmodule

### hdl/aefcc_checker.sv
// ----------------------------------------------------------------------------
// aefcc_checker
// Port-level checks for the encoder frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module aefcc_checker
    import aefcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_stall,
    input  logic              o_valid,
    input  logic              i_stall,
    input  logic [POS_W-1:0]  o_position,
    input  logic              o_crc_ok,
    input  logic              o_position_valid,
    input  logic              o_position_updated
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_position)
                               && $stable(o_crc_ok) && $stable(o_position_updated))
        else $error("result beat changed while stalled");

    // position only replaced by a good, valid frame
    a_upd_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_position_updated |-> o_crc_ok && o_position_valid)
        else $error("position updated without good valid frame");

    // a new result needs a byte taken the cycle before
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall))
        else $error("result beat without input beat");

    // result register empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result beat present after reset");

endmodule

bind absolute_encoder_frame_crc_check_top aefcc_checker u_aefcc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_position         (o_position),
    .o_crc_ok           (o_crc_ok),
    .o_position_valid   (o_position_valid),
    .o_position_updated (o_position_updated)
);

### test/frame_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_result_checker
// Follows encoder frame bytes into the checker block, predicts each result
// beat (flags, CRC status, held position) and compares it with the output.
// ----------------------------------------------------------------------------
package enc_frame_tb_pkg;

    localparam logic [31:0] GEN_POLY = 32'hDB00_0000;

    // CRC7 by plain long division, generator aligned at bit 31
    function automatic logic [6:0] crc7_of(input logic [25:0] bits);
        logic [31:0] w;
        w = {6'd0, bits};
        for (int k = 0; k < 32; k++) begin
            if (w[31]) w = w ^ GEN_POLY;
            if (k < 31) w = w << 1;
        end
        return w[30:24];
    endfunction

endpackage

module frame_result_checker
    import aefcc_pkg::*;
    import enc_frame_tb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_frame_start,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [POS_W-1:0]  i_position,
    input  logic              i_crc_ok,
    input  logic              i_position_valid,
    input  logic              i_synchronized,
    input  logic              i_zero_point_default,
    input  logic              i_stale_data,
    input  logic              i_position_updated,
    output int unsigned       o_mismatches,
    output int unsigned       o_pending
);

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             crc_ok;
        logic             pos_valid;
        logic             synced;
        logic             zero_point;
        logic             stale;
        logic             updated;
    } frame_result_t;

    logic [IDX_W-1:0] frame_idx     = IDX_IDLE;
    logic [39:0]      frame_sr      = '0;
    logic [POS_W-1:0] held_pos      = '0;
    int unsigned      mismatch_cnt  = 0;
    frame_result_t    expected_frames[$];

    assign o_mismatches = mismatch_cnt;

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // advance the frame tracker by one accepted beat
    task automatic follow_byte(input logic [7:0] b, input logic start);
        frame_result_t r;
        logic [7:0]    b1, b2, b3, b4, b5;
        if (start) begin
            frame_idx = IDX_FIRST;
            frame_sr  = '0;
        end else if (frame_idx >= IDX_FIRST && frame_idx <= IDX_LAST) begin
            frame_sr = {frame_sr[31:0], b};
            if (frame_idx != IDX_LAST) begin
                frame_idx = frame_idx + 3'd1;
            end else begin
                frame_idx = IDX_IDLE;
                {b1, b2, b3, b4, b5} = frame_sr;
                r.zero_point = b1[0];
                r.pos_valid  = b2[7];
                r.synced     = b2[6];
                r.stale      = b5[7];
                r.crc_ok     = (crc7_of({b1[0], b2, b3, b4, b5[7]}) == b5[6:0]);
                r.updated    = r.crc_ok && r.pos_valid;
                if (r.updated) held_pos = {b2[5:0], b3, b4};
                r.position   = held_pos;
                expected_frames.push_back(r);
            end
        end
    endtask

    always @(posedge i_clk) begin : track
        frame_result_t want;
        if (!i_rst_n) begin
            frame_idx = IDX_IDLE;
            frame_sr  = '0;
            held_pos  = '0;
            expected_frames.delete();
        end else begin
            if (i_in_valid && !i_in_stall) follow_byte(i_rx_byte, i_frame_start);
            if (i_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: result beat expected none actual position %h",
                             $time, i_position);
                    mismatch_cnt++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("position", want.position, i_position);
                    check_field("crc_ok", POS_W'(want.crc_ok), POS_W'(i_crc_ok));
                    check_field("position_valid", POS_W'(want.pos_valid),
                                POS_W'(i_position_valid));
                    check_field("synchronized", POS_W'(want.synced),
                                POS_W'(i_synchronized));
                    check_field("zero_point_default", POS_W'(want.zero_point),
                                POS_W'(i_zero_point_default));
                    check_field("stale_data", POS_W'(want.stale), POS_W'(i_stale_data));
                    check_field("position_updated", POS_W'(want.updated),
                                POS_W'(i_position_updated));
                end
            end
        end
        o_pending <= expected_frames.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives encoder frames (good, corrupted, cut short, over-long and noise)
// into the frame CRC checker with random sender gaps and receiver stalls;
// the result checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module testbench;

    import aefcc_pkg::*;
    import enc_frame_tb_pkg::*;

    localparam int unsigned ITEM_TARGET = 1400;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 20;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte     = '0;
    logic              frame_start = 1'b0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [POS_W-1:0]  position;
    logic              crc_ok;
    logic              position_valid;
    logic              synchronized;
    logic              zero_point_default;
    logic              stale_data;
    logic              position_updated;

    int unsigned       mismatches;
    int unsigned       pending;
    int unsigned       cycle_cnt   = 0;
    int unsigned       frame_items = 0;
    int unsigned       burst_left  = 0;

    logic              hold_tgl    = 1'b0;
    logic              hold_seen   = 1'b0;
    int unsigned       hold_left   = 0;
    int unsigned       mode_left   = 0;
    stall_mode_e       stall_mode  = STALL_NONE;

    absolute_encoder_frame_crc_check_top dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_valid              (in_valid),
        .o_stall              (in_stall),
        .i_rx_byte            (rx_byte),
        .i_frame_start        (frame_start),
        .o_valid              (out_valid),
        .i_stall              (out_stall),
        .o_position           (position),
        .o_crc_ok             (crc_ok),
        .o_position_valid     (position_valid),
        .o_synchronized       (synchronized),
        .o_zero_point_default (zero_point_default),
        .o_stale_data         (stale_data),
        .o_position_updated   (position_updated)
    );

    frame_result_checker chk (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_stall           (in_stall),
        .i_rx_byte            (rx_byte),
        .i_frame_start        (frame_start),
        .i_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .i_position           (position),
        .i_crc_ok             (crc_ok),
        .i_position_valid     (position_valid),
        .i_synchronized       (synchronized),
        .i_zero_point_default (zero_point_default),
        .i_stale_data         (stale_data),
        .i_position_updated   (position_updated),
        .o_mismatches         (mismatches),
        .o_pending            (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: a long hold on request, otherwise a randomly chosen pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= stall_mode_e'($urandom_range(0, 3));
                mode_left  <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
                default:     out_stall <= mode_left[2];
            endcase
        end
    end

    // one beat, with a random gap, possibly none, whenever a burst runs out
    task automatic send_beat(input logic [7:0] b, input logic start);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= start;
        burst_left--;
        frame_items++;
        do @(posedge clk); while (in_stall);
    endtask

    // start beat plus len body beats; beats past the fifth are random filler
    task automatic send_frame(input logic [7:0] lead, input logic [39:0] body,
                              input bit fix_crc, input int unsigned len);
        logic [39:0] f;
        f = body;
        if (fix_crc) f[6:0] = crc7_of({f[32], f[31:8], f[7]});
        send_beat(lead, 1'b1);
        for (int i = 0; i < len; i++)
            send_beat((i < 5) ? f[39 - 8*i -: 8] : 8'($urandom), 1'b0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        logic [39:0] body;
        int unsigned pick;
        int unsigned frame_no;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte outside any frame is dropped
        send_beat(8'hFF, 1'b0);
        // all-zero frame: CRC good, not valid, position kept
        send_frame(8'h00, 40'h00_0000_0000, 1'b1, 5);
        // every flag and position bit set, good CRC: position goes to max
        send_frame(8'hFF, 40'hFF_FFFF_FF80, 1'b1, 5);
        // partial frame cut off by a new start mark
        send_frame(8'h5A, 40'h01_C1_23_45_00, 1'b1, 2);
        // valid flag with a broken CRC, then a byte past the end
        send_frame(8'h00, 40'h00_8000_007F, 1'b0, 6);
        wait_drained();

        frame_no = 0;
        while (frame_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (frame_no == 60 || frame_no == 180) hold_tgl <= ~hold_tgl;
            if (frame_no == 120 || pick == 0) wait_drained();
            body = {8'($urandom), $urandom};
            body[31] = ($urandom_range(0, 9) < 7);
            if (pick < 70)
                send_frame(8'($urandom), body, $urandom_range(0, 4) != 0, 5);
            else if (pick < 82)
                send_frame(8'($urandom), body, 1'b1, $urandom_range(0, 4));
            else if (pick < 92)
                repeat ($urandom_range(1, 4))
                    send_beat(8'($urandom), $urandom_range(0, 7) == 0);
            else
                send_frame(8'($urandom), body, 1'b1, $urandom_range(6, 9));
            frame_no++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
